// ===== sv/ant_pkg.sv =====
// ----------------------------------------------------------------------------
// ant_pkg
// shared types and constants of the aging neighbor table
// ----------------------------------------------------------------------------
package ant_pkg;

    localparam int TABLE_SLOTS_DEF = 16;

    localparam int CFG_DATA_W = 16;

    localparam logic        CFG_AGE_LIMIT  = 1'b0;
    localparam logic        CFG_CEILING    = 1'b1;

    localparam logic [15:0] AGE_LIMIT_RST  = 16'd64;
    localparam logic [7:0]  CEILING_RST    = 8'd90;

    localparam logic        KIND_MSG       = 1'b0;
    localparam logic        KIND_PURGE     = 1'b1;

    typedef struct packed {
        logic [15:0] id;
        logic [31:0] stamp;
        logic [7:0]  distance;
        logic [7:0]  count;
        logic [7:0]  mode;
    } t_entry;

endpackage

// ===== sv/aging_neighbor_table.sv =====
// ----------------------------------------------------------------------------
// aging_neighbor_table
// neighbor table with id search, update or append, age purge and nearest
// distance report, walked one entry at a time over one write and one read port
// ----------------------------------------------------------------------------
// Holds up to TABLE_SLOTS-1 neighbor entries in a memory with one write port
// and one registered read port; every entry visit is a read followed by a
// check. A message searches the entries up to the hit (or all of them on a
// miss), writes the entry in place or appends it (over the last slot when
// full), then walks all entries for the nearest distance. A purge walks the
// entries from the last down, removing each aged one by moving the last entry
// into its slot, then does the same nearest-distance walk, or reports the
// ceiling when the table ends empty. The block returns to idle after each
// transaction before the next one is taken, and a finished transaction
// waits while the previous result is still stalled. The input side stalls
// while a transaction is in progress; the result is held in an output
// register so the next transaction is taken while it waits. The entry memory
// needs no clearing after reset; the user writes configuration only while no
// transaction is in progress, and the block itself does not enforce this.
module aging_neighbor_table
    import ant_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_kind,
    input  logic [31:0]           i_now_tick,
    input  logic [15:0]           i_sender_id,
    input  logic [7:0]            i_distance,
    input  logic [7:0]            i_sender_count,
    input  logic [7:0]            i_sender_mode,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [3:0]            o_entry_count,
    output logic [7:0]            o_nearest_distance,
    output logic                  o_was_known
);

    localparam int CAP = TABLE_SLOTS - 1;
    localparam int CW  = $clog2(TABLE_SLOTS);
    localparam int AW  = (CAP > 1) ? $clog2(CAP) : 1;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_MSG_RD    = 4'd1;
    localparam logic [3:0] S_MSG_CHK   = 4'd2;
    localparam logic [3:0] S_MSG_WR    = 4'd3;
    localparam logic [3:0] S_PRG_RD    = 4'd4;
    localparam logic [3:0] S_PRG_CHK   = 4'd5;
    localparam logic [3:0] S_PRG_MV_RD = 4'd6;
    localparam logic [3:0] S_PRG_MV    = 4'd7;
    localparam logic [3:0] S_MIN_RD    = 4'd8;
    localparam logic [3:0] S_MIN_CHK   = 4'd9;
    localparam logic [3:0] S_DONE      = 4'd10;

    t_entry        r_mem [CAP];
    t_entry        r_rd;

    logic [3:0]    r_state;
    logic [CW-1:0] r_count;
    logic [AW-1:0] r_addr;
    logic          r_known;
    logic [7:0]    r_best;
    logic          r_kind;
    t_entry        r_item;
    logic [15:0]   r_age_limit;
    logic [7:0]    r_ceiling;

    logic [CW-1:0] w_last;
    logic [AW-1:0] w_rd_addr;
    logic          w_at_last;
    logic [31:0]   w_age;
    logic          w_old;
    logic          w_we;

    assign w_last    = r_count - CW'(1);
    assign w_at_last = (CW'(r_addr) == w_last);
    assign w_rd_addr = (r_state == S_PRG_MV_RD) ? w_last[AW-1:0] : r_addr;
    assign w_age     = r_item.stamp - r_rd.stamp;
    assign w_old     = (w_age > {16'd0, r_age_limit});
    assign w_we      = (r_state == S_MSG_WR) || (r_state == S_PRG_MV);
    assign o_stall   = (r_state != S_IDLE);

    // entry memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_addr] <= (r_state == S_MSG_WR) ? r_item : r_rd;
        end
        r_rd <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_age_limit <= AGE_LIMIT_RST;
            r_ceiling   <= CEILING_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_AGE_LIMIT: r_age_limit <= i_cfg_data;
                CFG_CEILING:   r_ceiling   <= i_cfg_data[7:0];
                default:       r_ceiling   <= r_ceiling;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_addr  <= '0;
            r_known <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && !i_stall && r_state != S_DONE) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_kind          <= i_kind;
                        r_item.id       <= i_sender_id;
                        r_item.stamp    <= i_now_tick;
                        r_item.distance <= i_distance;
                        r_item.count    <= i_sender_count;
                        r_item.mode     <= i_sender_mode;
                        r_known         <= 1'b0;
                        if (i_kind == KIND_MSG) begin
                            r_addr <= '0;
                            if (r_count == '0) begin
                                r_count <= CW'(1);
                                r_state <= S_MSG_WR;
                            end else begin
                                r_state <= S_MSG_RD;
                            end
                        end else if (r_count == '0) begin
                            r_state <= S_MIN_RD;
                        end else begin
                            r_addr  <= w_last[AW-1:0];
                            r_state <= S_PRG_RD;
                        end
                    end
                end
                S_MSG_RD: r_state <= S_MSG_CHK;
                S_MSG_CHK: begin
                    if (r_rd.id == r_item.id) begin
                        r_known <= 1'b1;
                        r_state <= S_MSG_WR;
                    end else if (w_at_last) begin
                        r_state <= S_MSG_WR;
                        if (r_count < CW'(CAP)) begin
                            r_addr  <= r_count[AW-1:0];
                            r_count <= r_count + CW'(1);
                        end else begin
                            r_addr <= AW'(CAP - 1);
                        end
                    end else begin
                        r_addr  <= r_addr + AW'(1);
                        r_state <= S_MSG_RD;
                    end
                end
                S_MSG_WR: begin
                    r_addr  <= '0;
                    r_state <= S_MIN_RD;
                end
                S_PRG_RD: r_state <= S_PRG_CHK;
                S_PRG_CHK: begin
                    if (w_old && !w_at_last) begin
                        r_state <= S_PRG_MV_RD;
                    end else begin
                        if (w_old) begin
                            r_count <= w_last;
                        end
                        if (r_addr == '0) begin
                            r_state <= S_MIN_RD;
                        end else begin
                            r_addr  <= r_addr - AW'(1);
                            r_state <= S_PRG_RD;
                        end
                    end
                end
                S_PRG_MV_RD: r_state <= S_PRG_MV;
                S_PRG_MV: begin
                    r_count <= w_last;
                    if (r_addr == '0) begin
                        r_state <= S_MIN_RD;
                    end else begin
                        r_addr  <= r_addr - AW'(1);
                        r_state <= S_PRG_RD;
                    end
                end
                S_MIN_RD: begin
                    if (r_count == '0) begin
                        r_best  <= r_ceiling;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_MIN_CHK;
                    end
                end
                S_MIN_CHK: begin
                    if (r_addr == '0) begin
                        r_best <= (r_rd.distance < r_ceiling) ? r_rd.distance : r_ceiling;
                    end else if (r_rd.distance < r_best) begin
                        r_best <= r_rd.distance;
                    end
                    if (w_at_last) begin
                        r_state <= S_DONE;
                    end else begin
                        r_addr  <= r_addr + AW'(1);
                        r_state <= S_MIN_RD;
                    end
                end
                S_DONE: begin
                    if (!o_valid || !i_stall) begin
                        o_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!o_valid || !i_stall)) begin
            o_entry_count      <= 4'(r_count);
            o_nearest_distance <= r_best;
            o_was_known        <= r_known;
        end
    end

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAP))
        else $error("entry count above capacity");

    a_addr_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (CW'(r_addr) < CW'(CAP)))
        else $error("entry address out of range");

    a_purge_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_kind == KIND_PURGE) |-> !r_known)
        else $error("purge marked as known");

    a_nearest_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (r_best <= r_ceiling))
        else $error("nearest distance above ceiling");

    a_msg_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MSG_WR) |=> (r_count != '0))
        else $error("empty table after message");

endmodule
